[sv/assert_macros.svh]
// Assertion macros used by the effect generator's control module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an implication holds at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Checks that a condition holds in the cycle after another.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[sv/dmxfx_pkg.sv]
// ----------------------------------------------------------------------------
// dmxfx_pkg
// Shared types, constants and the sine table of the effect generator.
// ----------------------------------------------------------------------------
package dmxfx_pkg;

   localparam int CHANNELS_DEFAULT = 16;

   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_SET  = 1'b1;

   localparam logic [3:0] MODE_FIXED  = 4'd0;
   localparam logic [3:0] MODE_SQUARE = 4'd1;
   localparam logic [3:0] MODE_SAW    = 4'd2;
   localparam logic [3:0] MODE_SINE   = 4'd3;
   localparam logic [3:0] MODE_RAMP   = 4'd4;

   localparam int NUM_RATES = 10;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start_div;   // begin the ten base phase divisions
      logic latch_set;   // capture a set item's fields
      logic do_set;      // write the set channel's entry
      logic load_chan;   // register the entry of the scanned channel
      logic emit_chan;   // compute and present the scanned channel's result
      logic clr_scan;    // restart the channel scan
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_done;
      logic scan_end;    // scan index is the last channel
      logic chan_emits;  // loaded channel produces a result
      logic set_valid;   // latched set channel is in range
      logic set_emits;   // latched set produces a result
      logic any_after;   // an emitting channel follows the loaded one
   } ctl_sts_type;

   localparam logic [7:0] QSINE [0:64] = '{
      8'd128, 8'd131, 8'd134, 8'd137, 8'd140, 8'd143, 8'd146, 8'd149, 8'd152,
      8'd155, 8'd158, 8'd162, 8'd165, 8'd167, 8'd170, 8'd173, 8'd176, 8'd179,
      8'd182, 8'd185, 8'd188, 8'd190, 8'd193, 8'd196, 8'd198, 8'd201, 8'd203,
      8'd206, 8'd208, 8'd211, 8'd213, 8'd215, 8'd218, 8'd220, 8'd222, 8'd224,
      8'd226, 8'd228, 8'd230, 8'd232, 8'd234, 8'd235, 8'd237, 8'd238, 8'd240,
      8'd241, 8'd243, 8'd244, 8'd245, 8'd246, 8'd248, 8'd249, 8'd250, 8'd250,
      8'd251, 8'd252, 8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd255, 8'd255,
      8'd255, 8'd255
   };

   function automatic logic [7:0] sine_lookup(input logic [7:0] i);
      logic [7:0] r;
      if (i <= 8'd64)       r = QSINE[i[6:0]];
      else if (i < 8'd128)  r = QSINE[7'(8'd128 - i)];
      else if (i == 8'd128) r = 8'd128;
      else if (i <= 8'd192) r = 8'd255 - QSINE[7'(i - 8'd128)];
      else                  r = 8'd255 - QSINE[7'(9'd256 - {1'b0, i})];
      return r;
   endfunction

endpackage

[sv/dmxfx_divider.sv]
// ----------------------------------------------------------------------------
// dmxfx_divider
// Base phase unit: divides by the rate's constant divisor with shifts and a
// reciprocal multiplication, then reduces the quotient mod 255.
// ----------------------------------------------------------------------------
module dmxfx_divider
   import dmxfx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [3:0]  rate,
   output logic        done,
   output logic [7:0]  phase
);
   localparam logic [1:0] KIND_SHIFT  = 2'd0;
   localparam logic [1:0] KIND_DIV3   = 2'd1;
   localparam logic [1:0] KIND_DIV125 = 2'd2;

   // ceil(2^33/3) and ceil(2^35/125) are exact for every 32-bit dividend.
   localparam logic [31:0] RECIP_3   = 32'hAAAA_AAAB;
   localparam logic [31:0] RECIP_125 = 32'd274877907;

   logic [31:0] pre_ff, pre_in;
   logic [1:0]  kind_ff, kind_in;
   logic [31:0] quo_ff, quo_in;
   logic [7:0]  ph_ff, ph_in;
   logic        v1_ff, v2_ff, done_ff;
   logic [31:0] recip;
   logic [63:0] prod;
   logic [9:0]  fold1;
   logic [8:0]  fold2;

   // The power-of-two part of each divisor is shifted out first.
   always_comb begin
      pre_in  = dividend;
      kind_in = KIND_SHIFT;
      case (rate)
         4'd0: pre_in = {5'd0, dividend[31:5]};
         4'd1: pre_in = {4'd0, dividend[31:4]};
         4'd2: pre_in = {3'd0, dividend[31:3]};
         4'd3: pre_in = {2'd0, dividend[31:2]};
         4'd4: kind_in = KIND_DIV3;
         4'd5: pre_in = {1'b0, dividend[31:1]};
         4'd6: pre_in = dividend;
         4'd7: begin
            pre_in  = {2'd0, dividend[31:2]};
            kind_in = KIND_DIV125;
         end
         4'd8: begin
            pre_in  = {1'b0, dividend[31:1]};
            kind_in = KIND_DIV125;
         end
         default: kind_in = KIND_DIV125;
      endcase
   end

   always_comb begin
      recip = (kind_ff == KIND_DIV3) ? RECIP_3 : RECIP_125;
      prod  = {32'd0, pre_ff} * {32'd0, recip};
      case (kind_ff)
         KIND_DIV3:   quo_in = {1'b0, prod[63:33]};
         KIND_DIV125: quo_in = {3'd0, prod[63:35]};
         default:     quo_in = pre_ff;
      endcase
   end

   // 256 is 1 mod 255, so the bytes are summed and folded once more.
   always_comb begin
      fold1 = {2'd0, quo_ff[7:0]} + {2'd0, quo_ff[15:8]} +
              {2'd0, quo_ff[23:16]} + {2'd0, quo_ff[31:24]};
      fold2 = {1'b0, fold1[7:0]} + {7'd0, fold1[9:8]};
      ph_in = (fold2 >= 9'd255) ? 8'(fold2 - 9'd255) : fold2[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v1_ff   <= start;
         v2_ff   <= v1_ff;
         done_ff <= v2_ff;
      end
      pre_ff  <= pre_in;
      kind_ff <= kind_in;
      quo_ff  <= quo_in;
      ph_ff   <= ph_in;
   end

   assign done  = done_ff;
   assign phase = ph_ff;
endmodule

[sv/dmxfx_datapath.sv]
// ----------------------------------------------------------------------------
// dmxfx_datapath
// Channel tables, base phase computation and per-channel level generation.
// ----------------------------------------------------------------------------
module dmxfx_datapath
   import dmxfx_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   input  ctl_cmd_type cmd,
   output ctl_sts_type sts,
   input  logic [31:0] req_now_ms,
   input  logic [31:0] req_now_us,
   input  logic [7:0]  req_channel,
   input  logic [3:0]  req_effect_mode,
   input  logic [3:0]  req_rate_select,
   input  logic [7:0]  req_phase_offset,
   input  logic [7:0]  req_fixed_level,
   output logic [5:0]  res_channel,
   output logic [7:0]  res_level
);
   localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic [3:0] mode_ff  [CHANNELS];
   logic [3:0] rate_ff  [CHANNELS];
   logic [7:0] ofs_ff   [CHANNELS];
   logic [7:0] prev_ff  [CHANNELS];
   logic [7:0] ramp_ff  [CHANNELS];
   logic       fin_ff   [CHANNELS];

   logic [31:0] ms_ff, us_ff;
   logic [7:0]  base_ff [NUM_RATES];
   logic [3:0]  ridx_ff;
   logic        dstart_ff;
   logic        running_ff;
   logic        div_start, div_done;
   logic [7:0]  div_phase;
   logic [31:0] div_dividend;

   logic [IW:0] scan_ff;
   logic [7:0]  s_ch_ff;
   logic [3:0]  s_mode_ff, s_rate_ff;
   logic [7:0]  s_ofs_ff, s_lvl_ff;
   logic [3:0]  l_mode_ff;
   logic [7:0]  l_ph_ff, l_prev_ff, l_ramp_ff;
   logic        l_fin_ff;
   logic [5:0]  res_ch_ff;
   logic [7:0]  res_lvl_ff;
   logic [IW-1:0] sidx, cidx;
   logic [CHANNELS-1:0] emits_vec;
   logic [7:0]  ramp_new;
   logic        fin_new;
   logic [8:0]  ramp_sum;
   logic [7:0]  delta;

   function automatic logic [7:0] base_of(input logic [3:0] r,
                                          input logic [7:0] b [NUM_RATES]);
      logic [7:0] v;
      v = 8'd0;
      for (int k = 0; k < NUM_RATES; k++)
         if (r == 4'(k)) v = b[k];
      return v;
   endfunction

   function automatic logic mode_emits(input logic [3:0] m);
      return (m == MODE_SQUARE) || (m == MODE_SAW) || (m == MODE_SINE) ||
             (m == MODE_RAMP);
   endfunction

   assign div_start    = dstart_ff;
   assign div_dividend = (ridx_ff < 4'd7) ? ms_ff : us_ff;

   dmxfx_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .rate     (ridx_ff),
      .done     (div_done),
      .phase    (div_phase)
   );

   // The ten divisions run back to back; done is raised after the last.
   always_ff @(posedge clock) begin
      if (reset) begin
         ms_ff      <= '0;
         us_ff      <= '0;
         ridx_ff    <= '0;
         dstart_ff  <= 1'b0;
         running_ff <= 1'b0;
         for (int k = 0; k < NUM_RATES; k++) base_ff[k] <= '0;
      end else begin
         dstart_ff <= 1'b0;
         if (cmd.start_div) begin
            ms_ff      <= req_now_ms;
            us_ff      <= req_now_us;
            ridx_ff    <= '0;
            dstart_ff  <= 1'b1;
            running_ff <= 1'b1;
         end else if (div_done) begin
            base_ff[ridx_ff] <= div_phase;
            if (ridx_ff == 4'(NUM_RATES - 1)) begin
               running_ff <= 1'b0;
            end else begin
               ridx_ff   <= ridx_ff + 4'd1;
               dstart_ff <= 1'b1;
            end
         end
      end
   end

   assign sidx = scan_ff[IW-1:0];
   assign cidx = s_ch_ff[IW-1:0];

   always_comb begin
      for (int k = 0; k < CHANNELS; k++)
         emits_vec[k] = mode_emits(mode_ff[k]) && (IW'(k) > sidx);
   end

   always_comb begin
      sts.div_done   = div_done && (ridx_ff == 4'(NUM_RATES - 1)) && running_ff;
      sts.scan_end   = (scan_ff == (IW+1)'(CHANNELS - 1));
      sts.chan_emits = mode_emits(l_mode_ff);
      sts.set_valid  = ({1'b0, s_ch_ff} < 9'(CHANNELS));
      sts.set_emits  = (s_mode_ff == MODE_FIXED) || (s_mode_ff == MODE_RAMP);
      sts.any_after  = |emits_vec;
   end

   assign delta    = l_ph_ff - l_prev_ff;
   assign ramp_sum = {1'b0, l_ramp_ff} + {1'b0, delta};
   always_comb begin
      ramp_new = l_ramp_ff;
      fin_new  = l_fin_ff;
      if (!l_fin_ff && delta != 8'd0) begin
         if (ramp_sum >= 9'd255) begin
            ramp_new = 8'd255;
            fin_new  = 1'b1;
         end else begin
            ramp_new = ramp_sum[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= '0;
         for (int k = 0; k < CHANNELS; k++) begin
            mode_ff[k] <= '0;
            rate_ff[k] <= '0;
            ofs_ff[k]  <= '0;
            prev_ff[k] <= '0;
            ramp_ff[k] <= '0;
            fin_ff[k]  <= 1'b0;
         end
      end else begin
         if (cmd.clr_scan) scan_ff <= '0;
         if (cmd.do_set && sts.set_valid) begin
            mode_ff[cidx] <= s_mode_ff;
            rate_ff[cidx] <= s_rate_ff;
            ofs_ff[cidx]  <= s_ofs_ff;
            prev_ff[cidx] <= base_of(s_rate_ff, base_ff) + s_ofs_ff;
            if (s_mode_ff == MODE_FIXED) begin
               fin_ff[cidx]  <= 1'b0;
               ramp_ff[cidx] <= s_lvl_ff;
            end else if (s_mode_ff == MODE_RAMP) begin
               fin_ff[cidx]  <= 1'b0;
               ramp_ff[cidx] <= '0;
            end
         end
         if (cmd.emit_chan) begin
            if (l_mode_ff == MODE_RAMP) begin
               ramp_ff[sidx] <= ramp_new;
               fin_ff[sidx]  <= fin_new;
               if (!l_fin_ff) prev_ff[sidx] <= l_ph_ff;
            end
            scan_ff <= scan_ff + (IW+1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_set) begin
         s_ch_ff   <= req_channel;
         s_mode_ff <= req_effect_mode;
         s_rate_ff <= req_rate_select;
         s_ofs_ff  <= req_phase_offset;
         s_lvl_ff  <= req_fixed_level;
      end
      if (cmd.load_chan) begin
         l_mode_ff <= mode_ff[sidx];
         l_ph_ff   <= base_of(rate_ff[sidx], base_ff) + ofs_ff[sidx];
         l_prev_ff <= prev_ff[sidx];
         l_ramp_ff <= ramp_ff[sidx];
         l_fin_ff  <= fin_ff[sidx];
      end
      if (cmd.emit_chan) begin
         res_ch_ff <= 6'(sidx);
         case (l_mode_ff)
            MODE_SQUARE: res_lvl_ff <= l_ph_ff[7] ? 8'd255 : 8'd0;
            MODE_SAW:    res_lvl_ff <= l_ph_ff;
            MODE_SINE:   res_lvl_ff <= sine_lookup(l_ph_ff);
            default:     res_lvl_ff <= ramp_new;
         endcase
      end else if (cmd.do_set) begin
         res_ch_ff  <= s_ch_ff[5:0];
         res_lvl_ff <= (s_mode_ff == MODE_FIXED) ? s_lvl_ff : 8'd0;
      end
   end

   assign res_channel = res_ch_ff;
   assign res_level   = res_lvl_ff;
endmodule

[sv/dmxfx_control.sv]
// ----------------------------------------------------------------------------
// dmxfx_control
// Sequencer for tick scans and set items, and the result handshake.
// ----------------------------------------------------------------------------
module dmxfx_control
   import dmxfx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_last,
   output ctl_cmd_type cmd,
   input  ctl_sts_type sts
);
   `include "assert_macros.svh"

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_DIV  = 6'b000010,
      ST_LOAD = 6'b000100,
      ST_EVAL = 6'b001000,
      ST_SET  = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      last_ff, last_in;
   logic      tick_ff, tick_in;
   logic      more_ff, more_in;

   always_comb begin
      state_in = state_ff;
      last_in  = last_ff;
      tick_in  = tick_ff;
      more_in  = more_ff;
      cmd      = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_cmd == CMD_TICK) begin
                  cmd.start_div = 1'b1;
                  state_in = ST_DIV;
               end else begin
                  cmd.latch_set = 1'b1;
                  state_in = ST_SET;
               end
            end
         end
         ST_DIV: begin
            if (sts.div_done) begin
               cmd.clr_scan = 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load_chan = 1'b1;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            // Channels that emit nothing are stepped past without a result.
            cmd.emit_chan = 1'b1;
            more_in  = !sts.scan_end;
            tick_in  = 1'b1;
            last_in  = !sts.any_after;
            if (sts.chan_emits) state_in = ST_OUT;
            else if (sts.scan_end) state_in = ST_IDLE;
            else state_in = ST_LOAD;
         end
         ST_SET: begin
            cmd.do_set = 1'b1;
            tick_in = 1'b0;
            last_in = 1'b1;
            if (sts.set_valid && sts.set_emits) state_in = ST_OUT;
            else state_in = ST_IDLE;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               if (tick_ff && more_ff) state_in = ST_LOAD;
               else state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         last_ff  <= 1'b0;
         tick_ff  <= 1'b0;
         more_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
         tick_ff  <= tick_in;
         more_ff  <= more_in;
      end
   end

   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_last  = last_ff;

   `ASSERT_IMPL(a_ready_idle, clock, reset, req_ready, !rsp_valid)
   `ASSERT_NEXT(a_last_ends, clock, reset, rsp_valid && rsp_ready && rsp_last, !rsp_valid)
   `ASSERT_NEXT(a_set_one, clock, reset, state_ff == ST_SET, !req_ready || !rsp_valid)
endmodule

[sv/dmx_channel_effect_generator.sv]
// ----------------------------------------------------------------------------
// dmx_channel_effect_generator
// Per-channel lighting effect generator: fixed, square, saw, sine and ramp levels.
// ----------------------------------------------------------------------------
//   channel | direction | handshake            | payload
//   req_    | in        | req_valid/req_ready  | cmd, time, channel settings
//   rsp_    | out       | rsp_valid/rsp_ready  | channel, level, last
//
// A tick computes the ten base phases one after another, each through start,
// shift, reciprocal multiply and fold mod 255, then loads and evaluates each
// channel in turn and waits on the handshake of every result delivered.
// A set item writes its channel entry, then hands over any result it makes.
// Reset is synchronous and clears all channel state and the latched time.
// A stalled result holds the sequencer; no new item is taken until done.
// ----------------------------------------------------------------------------
module dmx_channel_effect_generator
   import dmxfx_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [31:0] req_now_ms,
   input  logic [31:0] req_now_us,
   input  logic [7:0]  req_channel,
   input  logic [3:0]  req_effect_mode,
   input  logic [3:0]  req_rate_select,
   input  logic [7:0]  req_phase_offset,
   input  logic [7:0]  req_fixed_level,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_out_channel,
   output logic [7:0]  rsp_out_level,
   output logic        rsp_last
);
   ctl_cmd_type cmd;
   ctl_sts_type sts;

   dmxfx_control u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_last  (rsp_last),
      .cmd       (cmd),
      .sts       (sts)
   );

   dmxfx_datapath #(.CHANNELS(CHANNELS)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_now_ms       (req_now_ms),
      .req_now_us       (req_now_us),
      .req_channel      (req_channel),
      .req_effect_mode  (req_effect_mode),
      .req_rate_select  (req_rate_select),
      .req_phase_offset (req_phase_offset),
      .req_fixed_level  (req_fixed_level),
      .res_channel      (rsp_out_channel),
      .res_level        (rsp_out_level)
   );
endmodule
